[design/pitu_pkg.sv]
`default_nettype none
package pitu_pkg;

   localparam int unsigned NUM_SOURCES  = 5;
   localparam int unsigned TIMER_SOURCE = 2;
   localparam int unsigned CSR_AW       = 4;

   localparam logic [6:0] VECTOR_BASE  = 7'h40;
   localparam logic [7:0] COUNT_MAX    = 8'hFF;
   localparam logic [5:0] DIV_MASK     = 6'h3F;

   // register index codes (paddr[3:2])
   typedef enum logic [1:0] {
      REG_COUNT_ENABLE = 2'd0,
      REG_RATE_MODE    = 2'd1,
      REG_RELOAD_VALUE = 2'd2,
      REG_ENABLE_MASK  = 2'd3
   } reg_index_type;

   // timer period select codes
   typedef enum logic [1:0] {
      RATE_256 = 2'd0,
      RATE_4   = 2'd1,
      RATE_16  = 2'd2,
      RATE_64  = 2'd3
   } rate_mode_type;

   typedef struct packed {
      logic                   count_enable;
      logic [1:0]             rate_mode;
      logic [7:0]             reload_value;
      logic [NUM_SOURCES-1:0] enable_mask;
   } cfg_type;

   typedef struct packed {
      logic                   at_boundary;
      logic [NUM_SOURCES-1:0] request_bits;
      logic                   master_on;
      logic                   master_off;
      logic                   enter_halt;
   } req_type;

   typedef struct packed {
      logic [7:0]             divider;
      logic [7:0]             timer_count;
      logic [NUM_SOURCES-1:0] pending_flags;
      logic                   service_valid;
      logic [6:0]             service_vector;
      logic                   halted;
      logic                   master_enable;
   } rsp_type;

   // phase bits that must be zero for a timer tick
   function automatic logic [7:0] period_mask(input logic [1:0] mode);
      logic [7:0] m;
      case (mode)
         RATE_256: m = 8'hFF;
         RATE_4:   m = 8'h03;
         RATE_16:  m = 8'h0F;
         RATE_64:  m = 8'h3F;
         default:  m = 8'hFF;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

[design/pitu_csr.sv]
`default_nettype none
module pitu_csr
   import pitu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output cfg_type                cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx   = reg_index_type'(paddr[3:2]);
   assign wr_en = psel && penable && pwrite;

   // decode a write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_COUNT_ENABLE: cfg_in.count_enable = pwdata[0];
            REG_RATE_MODE:    cfg_in.rate_mode    = pwdata[1:0];
            REG_RELOAD_VALUE: cfg_in.reload_value = pwdata[7:0];
            REG_ENABLE_MASK:  cfg_in.enable_mask  = pwdata[NUM_SOURCES-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_COUNT_ENABLE: prdata[0]               = cfg_ff.count_enable;
         REG_RATE_MODE:    prdata[1:0]             = cfg_ff.rate_mode;
         REG_RELOAD_VALUE: prdata[7:0]             = cfg_ff.reload_value;
         REG_ENABLE_MASK:  prdata[NUM_SOURCES-1:0] = cfg_ff.enable_mask;
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[design/pitu_tick.sv]
`default_nettype none
module pitu_tick
   import pitu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);

   logic [7:0]             phase_ff, phase_in;
   logic [7:0]             div_ff, div_in;
   logic [7:0]             count_ff, count_in;
   logic [NUM_SOURCES-1:0] flag_ff, flag_in;
   logic                   master_ff, master_in;
   logic                   halt_ff, halt_in;

   logic [NUM_SOURCES-1:0] flags_req;
   logic                   master_req;
   logic                   timer_tick;
   logic                   overflow;
   logic [NUM_SOURCES-1:0] flags_tmr;
   logic [NUM_SOURCES-1:0] ready;
   logic [2:0]             src_idx;
   logic                   take;

   // apply requests and master enable on/off (off wins over on)
   always_comb begin
      flags_req  = flag_ff | req.request_bits;
      master_req = req.master_off ? 1'b0 : (req.master_on ? 1'b1 : master_ff);
   end

   // advance phase, divider and timer
   always_comb begin
      phase_in   = phase_ff + 8'd1;
      div_in     = (phase_in[5:0] & DIV_MASK) == 6'd0 ? div_ff + 8'd1 : div_ff;
      timer_tick = cfg.count_enable && ((phase_in & period_mask(cfg.rate_mode)) == 8'd0);
      overflow   = timer_tick && (count_ff == COUNT_MAX);
      if (!timer_tick) begin
         count_in = count_ff;
      end else if (overflow) begin
         count_in = cfg.reload_value;
      end else begin
         count_in = count_ff + 8'd1;
      end
      flags_tmr = flags_req;
      if (overflow) begin
         flags_tmr[TIMER_SOURCE] = 1'b1;
      end
   end

   // pick the lowest enabled pending source
   always_comb begin
      ready   = cfg.enable_mask & flags_tmr;
      src_idx = '0;
      for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
         if (ready[i]) begin
            src_idx = 3'(i);
         end
      end
   end

   // service at a boundary
   always_comb begin
      take      = req.at_boundary && (|ready) && master_req;
      flag_in   = flags_tmr;
      master_in = master_req;
      halt_in   = halt_ff | req.enter_halt;
      if (req.at_boundary && (|ready)) begin
         halt_in = 1'b0;
      end
      if (take) begin
         flag_in[src_idx] = 1'b0;
         master_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         div_ff    <= '0;
         count_ff  <= '0;
         flag_ff   <= '0;
         master_ff <= 1'b0;
         halt_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         div_ff    <= div_in;
         count_ff  <= count_in;
         flag_ff   <= flag_in;
         master_ff <= master_in;
         halt_ff   <= halt_in;
      end
   end

   always_comb begin
      rsp.divider        = div_in;
      rsp.timer_count    = count_in;
      rsp.pending_flags  = flag_in;
      rsp.service_valid  = take;
      rsp.service_vector = take ? (VECTOR_BASE | {1'b0, src_idx, 3'b000}) : 7'd0;
      rsp.halted         = halt_in;
      rsp.master_enable  = master_in;
   end

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(flag_ff) && $stable(count_ff))
      else $error("tick state moved without an advancing beat");

   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      take |-> !master_in && !halt_in && !flag_in[src_idx])
      else $error("serviced source left master, halt or flag set");

   a_take_needs_master: assert property (@(posedge clock) disable iff (reset)
      advance && take |=> !master_ff)
      else $error("master enable survived a service");

   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> phase_ff == $past(phase_ff) + 8'd1)
      else $error("phase did not step by one");

endmodule
`default_nettype wire

[design/prescaled_timer_interrupt_unit_core.sv]
`default_nettype none
// A request beat is taken into the input register, then passed through the tick
// logic into the result register once that register is free.
// Throughput: one tick per cycle while the result is not stalled; the tick state updates in a single pass.
// A stalled result holds its register while one more request waits in the input register.
// Reset (synchronous, active high) clears phase, divider, timer, flags, master
// enable, halt and all configuration registers.
module prescaled_timer_interrupt_unit_core
   import pitu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_at_boundary,
   input  wire logic [NUM_SOURCES-1:0] req_request_bits,
   input  wire logic                   req_master_on,
   input  wire logic                   req_master_off,
   input  wire logic                   req_enter_halt,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_divider,
   output logic [7:0]                  rsp_timer_count,
   output logic [NUM_SOURCES-1:0]      rsp_pending_flags,
   output logic                        rsp_service_valid,
   output logic [6:0]                  rsp_service_vector,
   output logic                        rsp_halted,
   output logic                        rsp_master_enable,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_AW-1:0]      csr_paddr,
   input  wire logic [31:0]            csr_pwdata,
   output logic      [31:0]            csr_prdata,
   output logic                        csr_pready
);

   cfg_type cfg;
   req_type in_data_ff, in_data_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type tick_rsp;
   logic    accept;
   logic    move;

   assign csr_pready = 1'b1;

   pitu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   pitu_tick u_tick (
      .clock   (clock),
      .reset   (reset),
      .advance (move),
      .req     (in_data_ff),
      .cfg     (cfg),
      .rsp     (tick_rsp)
   );

   // handshake: advance the held beat when the result register frees up
   assign move      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !move;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = accept ? 1'b1 : (move ? 1'b0 : in_valid_ff);
      in_data_in  = in_data_ff;
      if (accept) begin
         in_data_in.at_boundary  = req_at_boundary;
         in_data_in.request_bits = req_request_bits;
         in_data_in.master_on    = req_master_on;
         in_data_in.master_off   = req_master_off;
         in_data_in.enter_halt   = req_enter_halt;
      end
      out_valid_in = move ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
      out_data_in  = move ? tick_rsp : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_divider        = out_data_ff.divider;
   assign rsp_timer_count    = out_data_ff.timer_count;
   assign rsp_pending_flags  = out_data_ff.pending_flags;
   assign rsp_service_valid  = out_data_ff.service_valid;
   assign rsp_service_vector = out_data_ff.service_vector;
   assign rsp_halted         = out_data_ff.halted;
   assign rsp_master_enable  = out_data_ff.master_enable;

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !move)
      else $error("held result beat overwritten");

   a_vector_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.service_valid |-> out_data_ff.service_vector == 7'd0)
      else $error("vector set without a service");

   a_service_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.service_valid
      |-> out_data_ff.service_vector[6] && !out_data_ff.master_enable && !out_data_ff.halted)
      else $error("service beat inconsistent with master or halt");

endmodule
`default_nettype wire

[tb/tb.sv]
`default_nettype none
module tb;
   import pitu_pkg::*;

   localparam int unsigned PHASE_TICKS = 185;
   localparam int unsigned HOLD_AT     = 600;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned QUIET_LIMIT = 2000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                cur_req = '0;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_divider;
   logic [7:0]             rsp_timer_count;
   logic [NUM_SOURCES-1:0] rsp_pending_flags;
   logic                   rsp_service_valid;
   logic [6:0]             rsp_service_vector;
   logic                   rsp_halted;
   logic                   rsp_master_enable;

   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr = '0;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   // ticks waiting to be offered, and results owed by the block
   req_type                pending_q[$];
   rsp_type                tick_expect_q[$];

   // shadow of the block's configuration and tick state
   cfg_type                shadow_cfg = '0;
   logic [7:0]             tick_phase = '0;
   logic [7:0]             div_count = '0;
   logic [7:0]             tmr_count = '0;
   logic [NUM_SOURCES-1:0] irq_flags = '0;
   logic                   ime = 1'b0;
   logic                   halt_flag = 1'b0;

   int unsigned            send_idle_max = 0;
   int unsigned            recv_idle_max = 0;
   int unsigned            send_wait = 0;
   int unsigned            recv_wait = 0;
   int unsigned            hold_left = 0;
   int unsigned            beats_seen = 0;
   int unsigned            quiet_cycles = 0;
   int unsigned            mismatches = 0;

   logic                   req_at_boundary;
   logic [NUM_SOURCES-1:0] req_request_bits;
   logic                   req_master_on;
   logic                   req_master_off;
   logic                   req_enter_halt;

   assign req_at_boundary  = cur_req.at_boundary;
   assign req_request_bits = cur_req.request_bits;
   assign req_master_on    = cur_req.master_on;
   assign req_master_off   = cur_req.master_off;
   assign req_enter_halt   = cur_req.enter_halt;

   prescaled_timer_interrupt_unit_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_at_boundary    (req_at_boundary),
      .req_request_bits   (req_request_bits),
      .req_master_on      (req_master_on),
      .req_master_off     (req_master_off),
      .req_enter_halt     (req_enter_halt),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_divider        (rsp_divider),
      .rsp_timer_count    (rsp_timer_count),
      .rsp_pending_flags  (rsp_pending_flags),
      .rsp_service_valid  (rsp_service_valid),
      .rsp_service_vector (rsp_service_vector),
      .rsp_halted         (rsp_halted),
      .rsp_master_enable  (rsp_master_enable),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // advance the shadow state by one tick and return the result it yields
   function automatic rsp_type step_tick(input req_type t);
      rsp_type    r;
      logic [7:0] pmask;
      r = '0;
      irq_flags = irq_flags | t.request_bits;
      if (t.master_on) ime = 1'b1;
      if (t.master_off) ime = 1'b0;
      if (t.enter_halt) halt_flag = 1'b1;

      tick_phase = tick_phase + 8'd1;
      if (tick_phase[5:0] == 6'd0) div_count = div_count + 8'd1;

      case (shadow_cfg.rate_mode)
         RATE_4:  pmask = 8'h03;
         RATE_16: pmask = 8'h0F;
         RATE_64: pmask = 8'h3F;
         default: pmask = 8'hFF;
      endcase
      if (shadow_cfg.count_enable && (tick_phase & pmask) == 8'd0) begin
         if (tmr_count == COUNT_MAX) begin
            tmr_count = shadow_cfg.reload_value;
            irq_flags[TIMER_SOURCE] = 1'b1;
         end else begin
            tmr_count = tmr_count + 8'd1;
         end
      end

      // any enabled pending source wakes; only the first one is serviced
      if (t.at_boundary) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            if (shadow_cfg.enable_mask[i] && irq_flags[i]) begin
               halt_flag = 1'b0;
               if (ime) begin
                  irq_flags[i]     = 1'b0;
                  ime              = 1'b0;
                  r.service_valid  = 1'b1;
                  r.service_vector = VECTOR_BASE + 7'(8 * i);
               end
            end
         end
      end

      r.divider       = div_count;
      r.timer_count   = tmr_count;
      r.pending_flags = irq_flags;
      r.halted        = halt_flag;
      r.master_enable = ime;
      return r;
   endfunction

   function automatic req_type mk_tick(input logic b, input logic [4:0] bits,
                                       input logic on, input logic off,
                                       input logic halt);
      req_type t;
      t.at_boundary  = b;
      t.request_bits = bits;
      t.master_on    = on;
      t.master_off   = off;
      t.enter_halt   = halt;
      return t;
   endfunction

   // mostly boundaries with sparse requests and frequent master-enable sets
   function automatic req_type rand_tick();
      req_type t;
      t.at_boundary  = ($urandom_range(0, 9) < 7);
      t.request_bits = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd0;
      t.master_on    = ($urandom_range(0, 9) < 3);
      t.master_off   = ($urandom_range(0, 9) < 1);
      t.enter_halt   = ($urandom_range(0, 9) < 1);
      return t;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_cfg(input logic en, input rate_mode_type mode,
                            input logic [7:0] reload, input logic [4:0] mask);
      csr_write(REG_COUNT_ENABLE, 32'(en));
      csr_write(REG_RATE_MODE, 32'(mode));
      csr_write(REG_RELOAD_VALUE, 32'(reload));
      csr_write(REG_ENABLE_MASK, 32'(mask));
      shadow_cfg.count_enable = en;
      shadow_cfg.rate_mode    = mode;
      shadow_cfg.reload_value = reload;
      shadow_cfg.enable_mask  = mask;
   endtask

   // wait until every tick is sent and every result is back
   task automatic drain();
      while (pending_q.size() != 0 || req_valid || tick_expect_q.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // driver: offer queued ticks, with a random gap after each beat
   always @(posedge clock) begin
      int unsigned g;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else if (!req_valid || !req_stall) begin
         g = send_wait;
         if (req_valid) begin
            tick_expect_q.push_back(step_tick(cur_req));
            g = $urandom_range(0, send_idle_max);
         end
         if (g != 0) begin
            req_valid <= 1'b0;
            send_wait <= g - 1;
         end else if (pending_q.size() != 0) begin
            cur_req   <= pending_q.pop_front();
            req_valid <= 1'b1;
            send_wait <= 0;
         end else begin
            req_valid <= 1'b0;
            send_wait <= 0;
         end
      end
   end

   // monitor: check each result beat, then stall at random
   always @(posedge clock) begin
      rsp_type     want;
      int unsigned w;
      logic        took;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait <= 0;
         hold_left <= 0;
      end else begin
         w    = recv_wait;
         took = rsp_valid && !rsp_stall;
         if (took) begin
            if (tick_expect_q.size() == 0) begin
               $error("result beat with no tick outstanding");
               mismatches++;
            end else begin
               want = tick_expect_q.pop_front();
               check_field("divider", want.divider, rsp_divider);
               check_field("timer_count", want.timer_count, rsp_timer_count);
               check_field("pending_flags", 8'(want.pending_flags), 8'(rsp_pending_flags));
               check_field("service_valid", 8'(want.service_valid), 8'(rsp_service_valid));
               check_field("service_vector", 8'(want.service_vector),
                           8'(rsp_service_vector));
               check_field("halted", 8'(want.halted), 8'(rsp_halted));
               check_field("master_enable", 8'(want.master_enable), 8'(rsp_master_enable));
            end
            beats_seen <= beats_seen + 1;
            w = $urandom_range(0, recv_idle_max);
         end else if (w != 0) begin
            w = w - 1;
         end
         recv_wait <= w;

         // hold off once for a long stretch so the block backs up
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (took && beats_seen == HOLD_AT - 1) begin
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (w != 0);
         end
      end
   end

   // watchdog: end the run if no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: priority, set/clear collision, halt entry and wake
      apply_cfg(1'b1, RATE_4, 8'hFE, 5'h1F);
      @(negedge clock);
      send_idle_max = 13;
      recv_idle_max = 13;
      pending_q.push_back(mk_tick(1'b0, 5'h00, 1'b0, 1'b0, 1'b0));
      pending_q.push_back(mk_tick(1'b0, 5'h1F, 1'b0, 1'b0, 1'b0));
      pending_q.push_back(mk_tick(1'b1, 5'h00, 1'b0, 1'b0, 1'b0));
      pending_q.push_back(mk_tick(1'b0, 5'h00, 1'b1, 1'b1, 1'b0));
      pending_q.push_back(mk_tick(1'b0, 5'h00, 1'b0, 1'b0, 1'b1));
      pending_q.push_back(mk_tick(1'b1, 5'h00, 1'b0, 1'b0, 1'b0));
      pending_q.push_back(mk_tick(1'b1, 5'h00, 1'b1, 1'b0, 1'b0));
      pending_q.push_back(mk_tick(1'b1, 5'h00, 1'b1, 1'b0, 1'b0));
      pending_q.push_back(mk_tick(1'b1, 5'h00, 1'b1, 1'b0, 1'b1));
      pending_q.push_back(mk_tick(1'b1, 5'h00, 1'b1, 1'b0, 1'b0));
      pending_q.push_back(mk_tick(1'b1, 5'h00, 1'b1, 1'b0, 1'b0));
      pending_q.push_back(mk_tick(1'b1, 5'h00, 1'b1, 1'b0, 1'b0));
      pending_q.push_back(mk_tick(1'b0, 5'h10, 1'b1, 1'b0, 1'b0));
      pending_q.push_back(mk_tick(1'b1, 5'h01, 1'b0, 1'b0, 1'b0));
      pending_q.push_back(mk_tick(1'b1, 5'h00, 1'b1, 1'b0, 1'b0));
      pending_q.push_back(mk_tick(1'b0, 5'h0A, 1'b0, 1'b1, 1'b1));
      pending_q.push_back(mk_tick(1'b0, 5'h00, 1'b0, 1'b0, 1'b0));
      pending_q.push_back(mk_tick(1'b1, 5'h15, 1'b1, 1'b1, 1'b0));
      drain();

      // random phases, each under its own configuration; some turn off sender or receiver idling
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: apply_cfg(1'b1, RATE_4, 8'hFF, 5'h1F);
            1: apply_cfg(1'b1, RATE_16, 8'hF0, 5'h05);
            2: apply_cfg(1'b0, RATE_256, 8'h00, 5'h00);
            3: apply_cfg(1'b1, RATE_64, 8'($urandom), 5'h04);
            4: apply_cfg(1'b1, RATE_256, 8'hFF, 5'h1F);
            5: apply_cfg(1'b1, RATE_4, 8'h00, 5'h1A);
            default: apply_cfg(1'($urandom), rate_mode_type'($urandom_range(0, 3)),
                               8'($urandom), 5'($urandom));
         endcase
         @(negedge clock);
         send_idle_max = (p == 2 || p == 5) ? 0 : 13;
         recv_idle_max = (p == 2 || p == 6) ? 0 : 13;
         repeat (PHASE_TICKS) pending_q.push_back(rand_tick());
         drain();
      end

      if (mismatches == 0 && tick_expect_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
